// ----- rtl/dwsp_pkg.sv -----
package dwsp_pkg;

    // Encoder count width and the fractional bits of the Q-format gains.
    localparam int COUNT_WIDTH    = 32;
    localparam int GAIN_FRAC_BITS = 8;

    // Fixed field widths.
    localparam int GAIN_WIDTH   = 16;
    localparam int ERR_WIDTH    = 32;
    localparam int TARGET_WIDTH = 31;
    localparam int LEVEL_WIDTH  = 8;
    localparam int DRIVE_WIDTH  = 9;
    localparam int MODE_WIDTH   = 2;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_SPEED    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TARGET_COUNTS = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRIVE_MODE    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_P        = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_I        = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_D        = 3'd5;

    // Drive modes. The unused code behaves as straight.
    localparam logic [MODE_WIDTH-1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_TURN_POS = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_TURN_NEG = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LEVEL_WIDTH-1:0]       RST_BASE_SPEED = 8'd255;
    localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_P     = 16'sd256;

    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = {LEVEL_WIDTH{1'b1}};

    // Internal arithmetic widths.
    localparam int SAT_IN_W = ((COUNT_WIDTH > ERR_WIDTH) ? COUNT_WIDTH : ERR_WIDTH) + 1;
    localparam int CMP_W    = ((COUNT_WIDTH > TARGET_WIDTH) ? COUNT_WIDTH : TARGET_WIDTH) + 1;
    localparam int PROD_W   = GAIN_WIDTH + ERR_WIDTH + 1;
    localparam int CORR_W   = PROD_W + 2;
    localparam int SCALED_W = ((CORR_W > LEVEL_WIDTH + GAIN_FRAC_BITS + 1) ?
                               CORR_W : LEVEL_WIDTH + GAIN_FRAC_BITS + 1) + 1;

    localparam logic signed [ERR_WIDTH-1:0] ERR_MAX = {1'b0, {(ERR_WIDTH-1){1'b1}}};
    localparam logic signed [ERR_WIDTH-1:0] ERR_MIN = {1'b1, {(ERR_WIDTH-1){1'b0}}};

    typedef logic signed [ERR_WIDTH-1:0] t_err;

    // Clamp a wider signed value into the error range.
    function automatic t_err sat_err(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(ERR_MAX);
        lo = SAT_IN_W'(ERR_MIN);
        if (v > hi) begin
            return ERR_MAX;
        end else if (v < lo) begin
            return ERR_MIN;
        end else begin
            return v[ERR_WIDTH-1:0];
        end
    endfunction

    // Map a scaled drive value to the 0..255 motor range.
    function automatic logic [LEVEL_WIDTH-1:0] drive_level(
        input logic signed [SCALED_W-1:0] scaled
    );
        logic signed [SCALED_W-1:0] top;
        top = $signed({{(SCALED_W-LEVEL_WIDTH){1'b0}}, LEVEL_MAX}) <<< GAIN_FRAC_BITS;
        if (scaled <= 0) begin
            return '0;
        end else if (scaled >= top) begin
            return LEVEL_MAX;
        end else begin
            return scaled[GAIN_FRAC_BITS +: LEVEL_WIDTH];
        end
    endfunction

endpackage

// ----- rtl/differential_wheel_sync_pid_core.sv -----
// Differential-drive wheel synchronizer with a PID correction.
//
// Input channel: one encoder sample per transfer (start request plus the
// absolute left and right counts), moved when i_in_valid is high and
// o_in_stall is low. Output channel: one drive command per sample (signed
// left and right drive plus a done flag), moved when o_out_valid is high and
// i_out_stall is low. Configuration writes use i_cfg_valid / o_cfg_ready; the
// port is always ready and must only be written while no sample is in flight.
//
// A sample passes through the input register and then the result register,
// which offers its command. Throughput is one sample per cycle while the
// receiver does not stall: the whole PID update, including the integral and
// previous-error state, is computed between the input and result registers, so
// consecutive samples chain through the state registers with no bubble.
//
// When the receiver stalls, the result register holds its command and the
// input register keeps one more sample; only when both are full is
// o_in_stall raised. Reset (synchronous, active low) empties both stages,
// clears origins, integral, previous error and the done flag, and returns
// every configuration register to its default.
module differential_wheel_sync_pid_core
    import dwsp_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]        i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]         i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_start_req,
    input  logic signed [COUNT_WIDTH-1:0]     i_left_count,
    input  logic signed [COUNT_WIDTH-1:0]     i_right_count,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [DRIVE_WIDTH-1:0]     o_left_drive,
    output logic signed [DRIVE_WIDTH-1:0]     o_right_drive,
    output logic                              o_done_res
);

    // Configuration registers.
    logic [LEVEL_WIDTH-1:0]        r_base_speed;
    logic [TARGET_WIDTH-1:0]       r_target_counts;
    logic [MODE_WIDTH-1:0]         r_drive_mode;
    logic signed [GAIN_WIDTH-1:0]  r_gain_p;
    logic signed [GAIN_WIDTH-1:0]  r_gain_i;
    logic signed [GAIN_WIDTH-1:0]  r_gain_d;

    // Controller state.
    logic [COUNT_WIDTH-1:0]        r_origin_left;
    logic [COUNT_WIDTH-1:0]        r_origin_right;
    t_err                          r_error_sum;
    t_err                          r_last_error;
    logic                          r_finished;

    // Input stage.
    logic                          r_in_valid;
    logic                          r_in_start;
    logic [COUNT_WIDTH-1:0]        r_in_left;
    logic [COUNT_WIDTH-1:0]        r_in_right;

    // Result stage.
    logic                          r_out_valid;
    logic signed [DRIVE_WIDTH-1:0] r_out_left;
    logic signed [DRIVE_WIDTH-1:0] r_out_right;
    logic                          r_out_done;

    // Next values produced by the update logic.
    logic [COUNT_WIDTH-1:0]        n_origin_left;
    logic [COUNT_WIDTH-1:0]        n_origin_right;
    t_err                          n_error_sum;
    t_err                          n_last_error;
    logic                          n_finished;
    logic signed [DRIVE_WIDTH-1:0] n_out_left;
    logic signed [DRIVE_WIDTH-1:0] n_out_right;
    logic                          n_out_done;

    logic out_free;
    logic advance;
    logic in_take;

    assign o_cfg_ready = 1'b1;

    // The result register frees when it is empty or being taken; the input
    // stage advances into it whenever it holds a sample and it is free.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed    <= RST_BASE_SPEED;
            r_target_counts <= '0;
            r_drive_mode    <= MODE_STRAIGHT;
            r_gain_p        <= RST_GAIN_P;
            r_gain_i        <= '0;
            r_gain_d        <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BASE_SPEED:    r_base_speed    <= i_cfg_data[LEVEL_WIDTH-1:0];
                CFG_TARGET_COUNTS: r_target_counts <= i_cfg_data[TARGET_WIDTH-1:0];
                CFG_DRIVE_MODE:    r_drive_mode    <= i_cfg_data[MODE_WIDTH-1:0];
                CFG_GAIN_P:        r_gain_p        <= $signed(i_cfg_data[GAIN_WIDTH-1:0]);
                CFG_GAIN_I:        r_gain_i        <= $signed(i_cfg_data[GAIN_WIDTH-1:0]);
                CFG_GAIN_D:        r_gain_d        <= $signed(i_cfg_data[GAIN_WIDTH-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Update logic: everything for the sample in the input stage.
    always_comb begin
        logic                          start;
        logic                          turn;
        t_err                          sum0;
        t_err                          last0;
        logic                          fin0;
        logic signed [COUNT_WIDTH-1:0] dl;
        logic signed [COUNT_WIDTH-1:0] dr;
        logic signed [CMP_W-1:0]       dl_ext;
        logic signed [CMP_W-1:0]       dr_ext;
        logic signed [CMP_W-1:0]       mag_l;
        logic signed [CMP_W-1:0]       mag_r;
        logic signed [CMP_W-1:0]       tgt;
        logic                          reached;
        logic signed [SAT_IN_W-1:0]    mix;
        t_err                          err;
        t_err                          sum1;
        logic signed [ERR_WIDTH:0]     deriv;
        logic signed [PROD_W-1:0]      p_p;
        logic signed [PROD_W-1:0]      p_i;
        logic signed [PROD_W-1:0]      p_d;
        logic signed [CORR_W-1:0]      corr;
        logic [LEVEL_WIDTH-1:0]        level;
        logic signed [SCALED_W-1:0]    lvl_scaled;
        logic [LEVEL_WIDTH-1:0]        drv_a;
        logic [LEVEL_WIDTH-1:0]        drv_b;
        logic signed [DRIVE_WIDTH-1:0] pos_a;
        logic signed [DRIVE_WIDTH-1:0] pos_b;

        start = r_in_start;
        turn  = (r_drive_mode == MODE_TURN_POS) || (r_drive_mode == MODE_TURN_NEG);

        // A start request takes this sample as the origin and clears the loop.
        n_origin_left  = start ? r_in_left  : r_origin_left;
        n_origin_right = start ? r_in_right : r_origin_right;
        sum0  = start ? '0 : r_error_sum;
        last0 = start ? '0 : r_last_error;
        fin0  = start ? 1'b0 : r_finished;

        dl = $signed(r_in_left  - n_origin_left);
        dr = $signed(r_in_right - n_origin_right);

        dl_ext = CMP_W'(dl);
        dr_ext = CMP_W'(dr);
        mag_l  = dl_ext[CMP_W-1] ? -dl_ext : dl_ext;
        mag_r  = dr_ext[CMP_W-1] ? -dr_ext : dr_ext;
        tgt    = $signed(CMP_W'(r_target_counts));
        if (turn) begin
            reached = (mag_l >= tgt) && (mag_r >= tgt);
        end else begin
            reached = (dl_ext >= tgt) && (dr_ext >= tgt);
        end

        // Straight mode steers on the wheel difference, turns on the sum.
        if (turn) begin
            mix = SAT_IN_W'(dl) + SAT_IN_W'(dr);
        end else begin
            mix = SAT_IN_W'(dl) - SAT_IN_W'(dr);
        end
        err   = sat_err(mix);
        sum1  = sat_err(SAT_IN_W'(sum0) + SAT_IN_W'(err));
        deriv = (ERR_WIDTH+1)'(err) - (ERR_WIDTH+1)'(last0);

        p_p  = PROD_W'(r_gain_p) * PROD_W'(err);
        p_i  = PROD_W'(r_gain_i) * PROD_W'(sum1);
        p_d  = PROD_W'(r_gain_d) * PROD_W'(deriv);
        corr = CORR_W'(p_p) + CORR_W'(p_i) + CORR_W'(p_d);

        level      = turn ? LEVEL_MAX : r_base_speed;
        lvl_scaled = $signed({{(SCALED_W-LEVEL_WIDTH){1'b0}}, level}) <<< GAIN_FRAC_BITS;
        drv_a      = drive_level(lvl_scaled - SCALED_W'(corr));
        drv_b      = drive_level(lvl_scaled + SCALED_W'(corr));
        pos_a      = $signed({1'b0, drv_a});
        pos_b      = $signed({1'b0, drv_b});

        n_error_sum  = sum0;
        n_last_error = last0;
        n_finished   = fin0;
        n_out_left   = '0;
        n_out_right  = '0;
        n_out_done   = 1'b1;

        if (!fin0) begin
            if (reached) begin
                // Target met: stop the motors and keep the loop state.
                n_finished = 1'b1;
            end else begin
                n_error_sum  = sum1;
                n_last_error = err;
                n_out_done   = 1'b0;
                case (r_drive_mode)
                    MODE_TURN_POS: begin
                        n_out_left  = pos_a;
                        n_out_right = -pos_b;
                    end
                    MODE_TURN_NEG: begin
                        n_out_left  = -pos_a;
                        n_out_right = pos_b;
                    end
                    default: begin
                        n_out_left  = pos_a;
                        n_out_right = pos_b;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_origin_left  <= '0;
            r_origin_right <= '0;
            r_error_sum    <= '0;
            r_last_error   <= '0;
            r_finished     <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid    <= 1'b1;
                r_origin_left  <= n_origin_left;
                r_origin_right <= n_origin_right;
                r_error_sum    <= n_error_sum;
                r_last_error   <= n_last_error;
                r_finished     <= n_finished;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_start <= i_start_req;
            r_in_left  <= i_left_count;
            r_in_right <= i_right_count;
        end
        if (advance) begin
            r_out_left  <= n_out_left;
            r_out_right <= n_out_right;
            r_out_done  <= n_out_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_out_left;
    assign o_right_drive = r_out_right;
    assign o_done_res    = r_out_done;

    // A finished command always has both motors stopped.
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> (r_out_left == '0 && r_out_right == '0))
        else $error("done result with a nonzero drive");

    // Once finished, a sample without a start request must report done.
    a_finished_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_finished && !r_in_start) |=> (r_out_valid && r_out_done))
        else $error("finished state produced a live drive");

    // In a positive turn the left wheel goes forward and the right one back.
    a_turn_pos_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done && r_drive_mode == MODE_TURN_POS)
        |-> (r_out_left >= 0 && r_out_right <= 0))
        else $error("positive turn drives with wrong signs");

endmodule
